// ----- rtl/tta_pkg.sv -----
// Shared types and constants for the torso tilt angle pipeline.
package tta_pkg;

	localparam int COORD_W = 16;
	localparam int CONF_W  = 8;
	localparam int ANGLE_W = 13;

	localparam logic [ANGLE_W-1:0] ANGLE_MAX = 13'd5760;

	// z accumulator counts 1/16384 degree
	localparam int Z_W        = 23;
	localparam int FRAC_SHIFT = 8;
	localparam logic [Z_W-1:0] ROUND_HALF = 23'd128;

	localparam logic [CONF_W-1:0] MIN_CONF_RESET = 8'd128;

	localparam int ATAN_LEN = 24;
	localparam int ATAN_W   = 20;

	// round(atan(2^-i) * 180/pi * 16384)
	localparam logic [ATAN_W-1:0] ATAN_TBL [ATAN_LEN] = '{
		20'd737280, 20'd435242, 20'd229970, 20'd116736,
		20'd58595,  20'd29326,  20'd14667,  20'd7334,
		20'd3667,   20'd1833,   20'd917,    20'd458,
		20'd229,    20'd115,    20'd57,     20'd29,
		20'd14,     20'd7,      20'd4,      20'd2,
		20'd1,      20'd0,      20'd0,      20'd0
	};

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [CONF_W-1:0]  conf;
	} kp_t;

	typedef struct packed {
		logic left_ok;
		logic right_ok;
		logic left_flat;
		logic right_flat;
	} side_t;

endpackage

// ----- rtl/tta_if.sv -----
// Channel interfaces: pose input, tilt result and threshold write.
interface tta_pose_if;
	logic                        valid;
	logic                        ready;
	logic [tta_pkg::COORD_W-1:0] left_shoulder_x;
	logic [tta_pkg::COORD_W-1:0] left_shoulder_y;
	logic [tta_pkg::CONF_W-1:0]  left_shoulder_conf;
	logic [tta_pkg::COORD_W-1:0] right_shoulder_x;
	logic [tta_pkg::COORD_W-1:0] right_shoulder_y;
	logic [tta_pkg::CONF_W-1:0]  right_shoulder_conf;
	logic [tta_pkg::COORD_W-1:0] left_hip_x;
	logic [tta_pkg::COORD_W-1:0] left_hip_y;
	logic [tta_pkg::CONF_W-1:0]  left_hip_conf;
	logic [tta_pkg::COORD_W-1:0] right_hip_x;
	logic [tta_pkg::COORD_W-1:0] right_hip_y;
	logic [tta_pkg::CONF_W-1:0]  right_hip_conf;

	modport source (
		output valid, left_shoulder_x, left_shoulder_y, left_shoulder_conf,
		right_shoulder_x, right_shoulder_y, right_shoulder_conf,
		left_hip_x, left_hip_y, left_hip_conf, right_hip_x, right_hip_y, right_hip_conf,
		input ready
	);
	modport sink (
		input valid, left_shoulder_x, left_shoulder_y, left_shoulder_conf,
		right_shoulder_x, right_shoulder_y, right_shoulder_conf,
		left_hip_x, left_hip_y, left_hip_conf, right_hip_x, right_hip_y, right_hip_conf,
		output ready
	);
endinterface

interface tta_tilt_if;
	logic                        valid;
	logic                        ready;
	logic                        angle_valid;
	logic [tta_pkg::ANGLE_W-1:0] tilt_angle;
	logic [1:0]                  sides_used;

	modport source (output valid, angle_valid, tilt_angle, sides_used, input ready);
	modport sink (input valid, angle_valid, tilt_angle, sides_used, output ready);
endinterface

interface tta_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [tta_pkg::CONF_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- rtl/torso_tilt_angle_top.sv -----
// Top level: torso tilt from vertical, pipelined two-lane CORDIC atan2.
//
//  channel | dir | handshake          | word
//  pose    | in  | pose.valid/ready   | four keypoints: x, y, confidence
//  tilt    | out | tilt.valid/ready   | angle_valid, tilt_angle, sides_used
//  cfg     | in  | cfg.valid/ready    | min_confidence threshold
//
// One word per cycle while tilt.ready is high; a word passes through prep,
// the one-iteration-per-stage CORDIC lanes, finish and the output register.
// arst_n clears the valid bits and loads the threshold with 128.
// Each stage holds while the stage after it is full and stalled, so bubbles
// close up; words enter while a result waits, until every stage is full.
module torso_tilt_angle_top #(
	parameter int COORD_WIDTH   = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	tta_pose_if.sink    pose,
	tta_tilt_if.source  tilt,
	tta_cfg_if.sink     cfg
);

	localparam int CW = COORD_WIDTH;
	localparam int N  = CORDIC_STAGES;
	localparam int XW = CW + N + 3;
	localparam int ZW = tta_pkg::Z_W;
	localparam int P  = N + 3;

	logic [tta_pkg::CONF_W-1:0] min_conf_q;

	logic [P:1] vld_s;
	logic [P:1] adv;

	tta_pkg::kp_t   ls, rs, lh, rh;
	tta_pkg::side_t side_s [N+2:1];
	logic [CW-1:0]  dx_s1 [2];
	logic [CW-1:0]  dy_s1 [2];

	logic signed [XW-1:0] x_s [N+1][2];
	logic signed [XW-1:0] y_s [N+1][2];
	logic signed [ZW-1:0] z_s [N+1][2];

	logic [1:0]                  flat;
	logic [tta_pkg::ANGLE_W-1:0] angle_s [2];
	logic [tta_pkg::ANGLE_W:0]   sum;
	logic [tta_pkg::ANGLE_W-1:0] angle;

	logic                        angle_valid_q;
	logic [tta_pkg::ANGLE_W-1:0] tilt_angle_q;
	logic [1:0]                  sides_used_q;

	// threshold register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_conf_q <= tta_pkg::MIN_CONF_RESET;
		end else if (cfg.valid) begin
			min_conf_q <= cfg.data;
		end
	end

	// stage advance chain
	always_comb begin
		adv[P] = !vld_s[P] || tilt.ready;
		for (int k = P - 1; k >= 1; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign pose.ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[1]) begin
				vld_s[1] <= pose.valid;
			end
			for (int k = 2; k <= P; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign ls = {pose.left_shoulder_x, pose.left_shoulder_y, pose.left_shoulder_conf};
	assign rs = {pose.right_shoulder_x, pose.right_shoulder_y, pose.right_shoulder_conf};
	assign lh = {pose.left_hip_x, pose.left_hip_y, pose.left_hip_conf};
	assign rh = {pose.right_hip_x, pose.right_hip_y, pose.right_hip_conf};

	tta_prep #(.CW(CW)) u_prep (
		.clk      (clk),
		.en       (adv[1]),
		.min_conf (min_conf_q),
		.ls       (ls),
		.rs       (rs),
		.lh       (lh),
		.rh       (rh),
		.side_s1  (side_s[1]),
		.dx_s1    (dx_s1),
		.dy_s1    (dy_s1)
	);

	// side flags ride along the CORDIC and finish stages
	for (genvar k = 2; k <= N + 2; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv[k]) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		assign x_s[0][l] = signed'({3'b000, dy_s1[l], {N{1'b0}}});
		assign y_s[0][l] = signed'({3'b000, dx_s1[l], {N{1'b0}}});
		assign z_s[0][l] = '0;

		for (genvar i = 0; i < N; i++) begin : g_stage
			tta_cordic_stage #(.XW(XW), .IDX(i)) u_stage (
				.clk (clk),
				.en  (adv[i+2]),
				.x_i (x_s[i][l]),
				.y_i (y_s[i][l]),
				.z_i (z_s[i][l]),
				.x_s (x_s[i+1][l]),
				.y_s (y_s[i+1][l]),
				.z_s (z_s[i+1][l])
			);
		end

		tta_finish u_finish (
			.clk     (clk),
			.en      (adv[N+2]),
			.flat    (flat[l]),
			.z       (z_s[N][l]),
			.angle_s (angle_s[l])
		);
	end

	assign flat = {side_s[N+1].right_flat, side_s[N+1].left_flat};

	// combine sides into the output word
	always_comb begin
		sum = {1'b0, angle_s[0]} + {1'b0, angle_s[1]};
		if (side_s[N+2].left_ok && side_s[N+2].right_ok) begin
			angle = sum[tta_pkg::ANGLE_W:1];
		end else if (side_s[N+2].left_ok) begin
			angle = angle_s[0];
		end else if (side_s[N+2].right_ok) begin
			angle = angle_s[1];
		end else begin
			angle = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[P]) begin
			angle_valid_q <= side_s[N+2].left_ok || side_s[N+2].right_ok;
			tilt_angle_q  <= angle;
			sides_used_q  <= {side_s[N+2].right_ok, side_s[N+2].left_ok};
		end
	end

	assign tilt.valid       = vld_s[P];
	assign tilt.angle_valid = angle_valid_q;
	assign tilt.tilt_angle  = tilt_angle_q;
	assign tilt.sides_used  = sides_used_q;

`ifndef SYNTHESIS
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		tilt.valid |-> tilt.tilt_angle <= tta_pkg::ANGLE_MAX)
		else $error("tilt angle above 90 degrees");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tilt.valid && !tilt.angle_valid |-> tilt.tilt_angle == '0 && tilt.sides_used == '0)
		else $error("invalid word carries angle or sides");

	a_valid_sides: assert property (@(posedge clk) disable iff (!arst_n)
		tilt.valid |-> tilt.angle_valid == (tilt.sides_used != 2'b00))
		else $error("angle_valid disagrees with sides_used");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!tilt.valid |-> pose.ready)
		else $error("input stalled with empty output stage");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		pose.valid && pose.ready |=> vld_s[1])
		else $error("accepted word missing from first stage");
`endif

endmodule

// ----- rtl/tta_prep.sv -----
// Front stage: side usability and absolute coordinate deltas.
module tta_prep #(
	parameter int CW = 16
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [tta_pkg::CONF_W-1:0] min_conf,
	input  tta_pkg::kp_t               ls,
	input  tta_pkg::kp_t               rs,
	input  tta_pkg::kp_t               lh,
	input  tta_pkg::kp_t               rh,
	output tta_pkg::side_t             side_s1,
	output logic [CW-1:0]              dx_s1 [2],
	output logic [CW-1:0]              dy_s1 [2]
);

	logic [CW-1:0] sx [2];
	logic [CW-1:0] sy [2];
	logic [CW-1:0] hx [2];
	logic [CW-1:0] hy [2];
	logic [CW-1:0] dx [2];
	logic [CW-1:0] dy [2];
	tta_pkg::side_t side;

	assign sx[0] = CW'(ls.x);
	assign sy[0] = CW'(ls.y);
	assign hx[0] = CW'(lh.x);
	assign hy[0] = CW'(lh.y);
	assign sx[1] = CW'(rs.x);
	assign sy[1] = CW'(rs.y);
	assign hx[1] = CW'(rh.x);
	assign hy[1] = CW'(rh.y);

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			dx[i] = (sx[i] >= hx[i]) ? (sx[i] - hx[i]) : (hx[i] - sx[i]);
			dy[i] = (sy[i] >= hy[i]) ? (sy[i] - hy[i]) : (hy[i] - sy[i]);
		end
		side.left_ok    = (ls.conf > min_conf) && (lh.conf > min_conf);
		side.right_ok   = (rs.conf > min_conf) && (rh.conf > min_conf);
		side.left_flat  = (dy[0] == '0);
		side.right_flat = (dy[1] == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side;
			dx_s1   <= dx;
			dy_s1   <= dy;
		end
	end

endmodule

// ----- rtl/tta_cordic_stage.sv -----
// One registered vectoring CORDIC iteration for one lane.
module tta_cordic_stage #(
	parameter int XW  = 35,
	parameter int IDX = 0
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [XW-1:0]           x_i,
	input  logic signed [XW-1:0]           y_i,
	input  logic signed [tta_pkg::Z_W-1:0] z_i,
	output logic signed [XW-1:0]           x_s,
	output logic signed [XW-1:0]           y_s,
	output logic signed [tta_pkg::Z_W-1:0] z_s
);

	localparam int ZW = tta_pkg::Z_W;
	localparam logic signed [ZW-1:0] ANG = ZW'(tta_pkg::ATAN_TBL[IDX]);

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic signed [XW-1:0] x_n;
	logic signed [XW-1:0] y_n;
	logic signed [ZW-1:0] z_n;

	always_comb begin
		xs  = x_i >>> IDX;
		ys  = y_i >>> IDX;
		x_n = x_i;
		y_n = y_i;
		z_n = z_i;
		if (y_i[XW-1]) begin
			x_n = x_i - ys;
			y_n = y_i + xs;
			z_n = z_i - ANG;
		end else if (y_i != '0) begin
			x_n = x_i + ys;
			y_n = y_i - xs;
			z_n = z_i + ANG;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s <= x_n;
			y_s <= y_n;
			z_s <= z_n;
		end
	end

endmodule

// ----- rtl/tta_finish.sv -----
// Per-lane angle rounding, clamping and flat-side override.
module tta_finish (
	input  logic                           clk,
	input  logic                           en,
	input  logic                           flat,
	input  logic signed [tta_pkg::Z_W-1:0] z,
	output logic [tta_pkg::ANGLE_W-1:0]    angle_s
);

	localparam int ZW = tta_pkg::Z_W;

	logic signed [ZW-1:0]          zr;
	logic [tta_pkg::ANGLE_W-1:0]   angle;

	always_comb begin
		zr = (z + signed'(tta_pkg::ROUND_HALF)) >>> tta_pkg::FRAC_SHIFT;
		if (flat) begin
			angle = tta_pkg::ANGLE_MAX;
		end else if (z[ZW-1]) begin
			angle = '0;
		end else if (zr > signed'(ZW'(tta_pkg::ANGLE_MAX))) begin
			angle = tta_pkg::ANGLE_MAX;
		end else begin
			angle = zr[tta_pkg::ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s <= angle;
		end
	end

endmodule
